/* rtl/core/opus_pkg.sv */
// opus_pkg: shared constants, types and helpers of the OLED pixel update sequencer.
// Used by opus_front, opus_queue, opus_back and the top level. No dependencies.

package opus_pkg;

   // Display geometry
   localparam int DISPLAY_WIDTH  = 128;
   localparam int DISPLAY_HEIGHT = 64;
   localparam int PAGE_ROWS      = 8;

   localparam int PAGE_COUNT  = DISPLAY_HEIGHT / PAGE_ROWS;
   localparam int STORE_DEPTH = DISPLAY_WIDTH * PAGE_COUNT;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int PAGE_W      = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

   // Fixed field widths
   localparam int COL_W  = 7;
   localparam int ROW_W  = 6;
   localparam int BYTE_W = 8;
   localparam int BIT_W  = 3;

   // Controller command codes
   localparam logic [BYTE_W-1:0] OP_COLUMN_RANGE = 8'h21;
   localparam logic [BYTE_W-1:0] OP_PAGE_RANGE   = 8'h22;

   // One classified pixel update waiting for the back end
   typedef struct packed {
      logic [COL_W-1:0]  column;
      logic [PAGE_W-1:0] page;
      logic [ADDR_W-1:0] addr;
      logic [BYTE_W-1:0] mask;
      logic              turn_on;
   } entry_type;

   // Transaction slot within one update
   typedef enum logic [6:0] {
      STEP_COL_OP     = 7'b0000001,
      STEP_COL_START  = 7'b0000010,
      STEP_COL_END    = 7'b0000100,
      STEP_PAGE_OP    = 7'b0001000,
      STEP_PAGE_START = 7'b0010000,
      STEP_PAGE_END   = 7'b0100000,
      STEP_DATA       = 7'b1000000
   } step_type;

   // Back-end sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EMIT  = 3'b100
   } state_type;

   // Queue status seen by its producer and consumer
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

/* rtl/core/opus_front.sv */
// opus_front: accepts pixel requests, drops out-of-range ones, and turns the
// rest into a store address, page number and bit mask. Depends on opus_pkg.

module opus_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [opus_pkg::COL_W-1:0]       req_column,
   input  logic [opus_pkg::ROW_W-1:0]       req_row,
   input  logic                             req_turn_on,
   input  logic                             store_ready,
   input  opus_pkg::qstat_type              q_stat,
   output logic                             q_push,
   output opus_pkg::entry_type              q_wdata
);

   logic                            in_range;
   logic [opus_pkg::ROW_W-1:0]      page_full;
   logic [opus_pkg::BIT_W-1:0]      bit_sel;
   logic [opus_pkg::ADDR_W+8:0]     addr_wide;

   // Stall while the store is being cleared or the queue has no room
   assign req_ready = store_ready & ~q_stat.full;

   // Range check against the display size
   assign in_range = (32'(req_column) < 32'(opus_pkg::DISPLAY_WIDTH)) &&
                     (32'(req_row) < 32'(opus_pkg::DISPLAY_HEIGHT));

   // Page and bit within the page
   assign page_full = opus_pkg::ROW_W'(req_row / opus_pkg::PAGE_ROWS);
   assign bit_sel   = opus_pkg::BIT_W'(req_row % opus_pkg::PAGE_ROWS);
   assign addr_wide = (opus_pkg::ADDR_W+9)'(page_full) *
                      (opus_pkg::ADDR_W+9)'(opus_pkg::DISPLAY_WIDTH) +
                      (opus_pkg::ADDR_W+9)'(req_column);

   always_comb begin
      q_wdata.column  = req_column;
      q_wdata.page    = opus_pkg::PAGE_W'(page_full);
      q_wdata.addr    = opus_pkg::ADDR_W'(addr_wide);
      q_wdata.mask    = opus_pkg::BYTE_W'(1) << bit_sel;
      q_wdata.turn_on = req_turn_on;
   end

   // Out-of-range items are taken but never queued
   assign q_push = req_valid & req_ready & in_range;

endmodule

/* rtl/core/opus_queue.sv */
// opus_queue: two-entry queue of classified updates between front and back end.
// Depends on opus_pkg.

module opus_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  opus_pkg::entry_type wdata,
   input  logic                pop,
   output opus_pkg::entry_type rdata,
   output opus_pkg::qstat_type stat
);

   opus_pkg::entry_type slot_ff [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff, count_in;

   assign stat.full  = (count_ff == 2'd2);
   assign stat.empty = (count_ff == 2'd0);
   assign rdata      = slot_ff[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

/* rtl/core/opus_back.sv */
// opus_back: framebuffer memory with clearing pass, read-modify-write of the
// addressed byte, and the seven-transaction output sequencer. Depends on opus_pkg.

module opus_back (
   input  logic                          clock,
   input  logic                          reset,
   input  opus_pkg::entry_type           q_rdata,
   input  opus_pkg::qstat_type           q_stat,
   output logic                          q_pop,
   output logic                          store_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_is_data,
   output logic [opus_pkg::BYTE_W-1:0]   rsp_byte_value,
   output logic                          rsp_last
);

   logic [opus_pkg::BYTE_W-1:0] mem [opus_pkg::STORE_DEPTH];

   opus_pkg::state_type          state_ff, state_in;
   logic [opus_pkg::ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   opus_pkg::entry_type          cur_ff;
   opus_pkg::step_type           step_ff, step_in;
   logic                         rmw_ff;
   logic [opus_pkg::BYTE_W-1:0]  rd_data_ff;
   logic [opus_pkg::BYTE_W-1:0]  new_byte_ff, new_byte;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_is_data_ff, rsp_is_data_in;
   logic [opus_pkg::BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic                         out_take;
   logic                         load;
   logic                         clearing;
   logic                         mem_we;
   logic [opus_pkg::ADDR_W-1:0]  mem_waddr;
   logic [opus_pkg::BYTE_W-1:0]  mem_wdata;

   assign clearing    = (state_ff == opus_pkg::ST_CLEAR);
   assign store_ready = ~clearing;
   assign out_take    = rsp_valid_ff & rsp_ready;

   // Take the next update when idle or as the last transaction leaves
   assign q_pop = ~q_stat.empty &
                  ((state_ff == opus_pkg::ST_IDLE) |
                   ((state_ff == opus_pkg::ST_EMIT) & out_take &
                    (step_ff == opus_pkg::STEP_DATA)));
   assign load  = q_pop | (out_take & (step_ff != opus_pkg::STEP_DATA));

   // Modified byte from the registered read
   assign new_byte = cur_ff.turn_on ? (rd_data_ff | cur_ff.mask)
                                    : (rd_data_ff & ~cur_ff.mask);

   // Memory write: clearing pass or write-back
   always_comb begin
      mem_we    = clearing | rmw_ff;
      mem_waddr = clearing ? clr_addr_ff : cur_ff.addr;
      mem_wdata = clearing ? '0 : new_byte;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (q_pop) begin
         rd_data_ff <= mem[q_rdata.addr];
      end
   end

   // Sequencer state and step
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      step_in     = step_ff;
      case (state_ff)
         opus_pkg::ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == opus_pkg::ADDR_W'(opus_pkg::STORE_DEPTH - 1)) begin
               state_in = opus_pkg::ST_IDLE;
            end
         end
         opus_pkg::ST_IDLE: begin
            if (q_pop) begin
               state_in = opus_pkg::ST_EMIT;
               step_in  = opus_pkg::STEP_COL_OP;
            end
         end
         opus_pkg::ST_EMIT: begin
            if (out_take) begin
               case (step_ff)
                  opus_pkg::STEP_COL_OP:     step_in = opus_pkg::STEP_COL_START;
                  opus_pkg::STEP_COL_START:  step_in = opus_pkg::STEP_COL_END;
                  opus_pkg::STEP_COL_END:    step_in = opus_pkg::STEP_PAGE_OP;
                  opus_pkg::STEP_PAGE_OP:    step_in = opus_pkg::STEP_PAGE_START;
                  opus_pkg::STEP_PAGE_START: step_in = opus_pkg::STEP_PAGE_END;
                  opus_pkg::STEP_PAGE_END:   step_in = opus_pkg::STEP_DATA;
                  default: begin
                     step_in  = opus_pkg::STEP_COL_OP;
                     state_in = q_pop ? opus_pkg::ST_EMIT : opus_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         default: state_in = opus_pkg::ST_CLEAR;
      endcase
   end

   // Output register contents for the slot being loaded
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_is_data_in = rsp_is_data_ff;
      rsp_byte_in    = rsp_byte_ff;
      rsp_last_in    = rsp_last_ff;
      if (out_take) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in   = 1'b1;
         rsp_is_data_in = 1'b0;
         rsp_last_in    = 1'b0;
         if (q_pop) begin
            rsp_byte_in = opus_pkg::OP_COLUMN_RANGE;
         end else begin
            case (step_ff)
               opus_pkg::STEP_COL_OP,
               opus_pkg::STEP_COL_START:  rsp_byte_in = opus_pkg::BYTE_W'(cur_ff.column);
               opus_pkg::STEP_COL_END:    rsp_byte_in = opus_pkg::OP_PAGE_RANGE;
               opus_pkg::STEP_PAGE_OP,
               opus_pkg::STEP_PAGE_START: rsp_byte_in = opus_pkg::BYTE_W'(cur_ff.page);
               default: begin
                  rsp_byte_in    = new_byte_ff;
                  rsp_is_data_in = 1'b1;
                  rsp_last_in    = 1'b1;
               end
            endcase
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= opus_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         step_ff      <= opus_pkg::STEP_COL_OP;
         rmw_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         step_ff      <= step_in;
         rmw_ff       <= q_pop;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_rdata;
      end
      if (rmw_ff) begin
         new_byte_ff <= new_byte;
      end
      rsp_is_data_ff <= rsp_is_data_in;
      rsp_byte_ff    <= rsp_byte_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_is_data    = rsp_is_data_ff;
   assign rsp_byte_value = rsp_byte_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

/* rtl/core/oled_pixel_update_sequencer_top.sv */
// OLED pixel update sequencer, top level.
// Instantiates opus_front, opus_queue and opus_back; depends on opus_pkg.
//
// Usage:
//  - req channel: one item per pixel (req_column, req_row, req_turn_on), valid/ready.
//    The addressed framebuffer byte is updated by read-modify-write; clear
//    touches only the addressed bit. Out-of-range pixels are taken and dropped.
//  - rsp channel: seven items per pixel: commands 0x21 col col, 0x22 page page
//    (rsp_is_data low), then the new byte as data with rsp_last high.
//  - With the back end idle, an accepted item is written into the queue, then
//    popped into the result register, which raises rsp_valid.
//  - Results leave one per cycle while rsp_ready is high; the next item's
//    memory read overlaps the previous item's tail.
//  - A two-entry queue separates request intake from the output sequencer, so
//    besides the item being sent, up to two more are taken while the receiver
//    stalls; the result register holds its item until rsp_ready.
//  - Reset: a clearing pass zeroes all STORE_DEPTH bytes of the framebuffer
//    (1024 at 128x64), one byte per cycle; req_ready stays low until it ends.

module oled_pixel_update_sequencer_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [opus_pkg::COL_W-1:0]      req_column,
   input  logic [opus_pkg::ROW_W-1:0]      req_row,
   input  logic                            req_turn_on,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_is_data,
   output logic [opus_pkg::BYTE_W-1:0]     rsp_byte_value,
   output logic                            rsp_last
);

   opus_pkg::entry_type q_wdata;
   opus_pkg::entry_type q_rdata;
   opus_pkg::qstat_type q_stat;
   logic                q_push;
   logic                q_pop;
   logic                store_ready;

   opus_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_column  (req_column),
      .req_row     (req_row),
      .req_turn_on (req_turn_on),
      .store_ready (store_ready),
      .q_stat      (q_stat),
      .q_push      (q_push),
      .q_wdata     (q_wdata)
   );

   opus_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .stat  (q_stat)
   );

   opus_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_rdata        (q_rdata),
      .q_stat         (q_stat),
      .q_pop          (q_pop),
      .store_ready    (store_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_is_data    (rsp_is_data),
      .rsp_byte_value (rsp_byte_value),
      .rsp_last       (rsp_last)
   );

endmodule

/* tb/sv/tb_oled_pixel_update_sequencer_top.sv */
// Self-checking testbench for oled_pixel_update_sequencer_top: pixel requests in,
// controller bus transactions out, checked against a framebuffer shadow copy.
// Depends on opus_pkg and the RTL of the top level only.

module tb_oled_pixel_update_sequencer_top;

   // Cycles without any accepted item before the run is declared hung
   localparam int STALL_LIMIT = 5000;
   localparam int TAIL_CYCLES = 20;
   localparam int RANDOM_ITEMS = 290;
   localparam int BLOCK_ITEMS = 30;

   // Shadow framebuffer and the bus transactions each pixel update must produce
   class pixel_bus_scoreboard_type;
      localparam logic KIND_CMD  = 1'b0;
      localparam logic KIND_DATA = 1'b1;

      typedef struct packed {
         logic                        is_data;
         logic [opus_pkg::BYTE_W-1:0] byte_value;
         logic                        last;
      } bus_txn_type;

      logic [opus_pkg::BYTE_W-1:0] frame_copy [opus_pkg::STORE_DEPTH];
      bus_txn_type                 pending_txns [$];
      int                          fault_count;

      function new();
         foreach (frame_copy[i]) frame_copy[i] = '0;
         fault_count = 0;
      endfunction

      function void push_txn(logic is_data, logic [opus_pkg::BYTE_W-1:0] value,
                             logic last);
         bus_txn_type t;
         t.is_data    = is_data;
         t.byte_value = value;
         t.last       = last;
         pending_txns.push_back(t);
      endfunction

      // Read-modify-write of the addressed byte, then the seven transactions
      function void note_request(logic [opus_pkg::COL_W-1:0] col,
                                 logic [opus_pkg::ROW_W-1:0] row, logic on);
         int                          unsigned page_idx;
         int                          unsigned bit_idx;
         int                          unsigned addr;
         logic [opus_pkg::BYTE_W-1:0] page_byte;
         logic [opus_pkg::BYTE_W-1:0] new_byte;
         if (int'(col) >= opus_pkg::DISPLAY_WIDTH ||
             int'(row) >= opus_pkg::DISPLAY_HEIGHT) return;
         page_idx  = int'(row) / opus_pkg::PAGE_ROWS;
         bit_idx   = int'(row) % opus_pkg::PAGE_ROWS;
         addr      = page_idx * opus_pkg::DISPLAY_WIDTH + int'(col);
         page_byte = opus_pkg::BYTE_W'(page_idx);
         new_byte  = frame_copy[addr];
         new_byte[bit_idx] = on;
         frame_copy[addr] = new_byte;
         push_txn(KIND_CMD, opus_pkg::OP_COLUMN_RANGE, 1'b0);
         push_txn(KIND_CMD, opus_pkg::BYTE_W'(col), 1'b0);
         push_txn(KIND_CMD, opus_pkg::BYTE_W'(col), 1'b0);
         push_txn(KIND_CMD, opus_pkg::OP_PAGE_RANGE, 1'b0);
         push_txn(KIND_CMD, page_byte, 1'b0);
         push_txn(KIND_CMD, page_byte, 1'b0);
         push_txn(KIND_DATA, new_byte, 1'b1);
      endfunction

      // One line per mismatch
      task report_mismatch(string msg);
         $display("%0t mismatch: %s", $time, msg);
         fault_count++;
      endtask

      task check_result(logic is_data, logic [opus_pkg::BYTE_W-1:0] value, logic last);
         bus_txn_type want;
         if (pending_txns.size() == 0) begin
            report_mismatch($sformatf("unexpected item is_data=%0b byte=%02h last=%0b",
                                      is_data, value, last));
            return;
         end
         want = pending_txns.pop_front();
         if (is_data !== want.is_data)
            report_mismatch($sformatf("is_data %0b, want %0b", is_data, want.is_data));
         if (value !== want.byte_value)
            report_mismatch($sformatf("byte_value %02h, want %02h", value, want.byte_value));
         if (last !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", last, want.last));
      endtask

      function int pending();
         return pending_txns.size();
      endfunction
   endclass

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic [opus_pkg::COL_W-1:0]  req_column;
   logic [opus_pkg::ROW_W-1:0]  req_row;
   logic                        req_turn_on;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic                        rsp_is_data;
   logic [opus_pkg::BYTE_W-1:0] rsp_byte_value;
   logic                        rsp_last;

   pixel_bus_scoreboard_type bus_sb = new();
   int                       idle_cycles = 0;
   bit                       burst_mode = 1'b0;

   oled_pixel_update_sequencer_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_column     (req_column),
      .req_row        (req_row),
      .req_turn_on    (req_turn_on),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_is_data    (rsp_is_data),
      .rsp_byte_value (rsp_byte_value),
      .rsp_last       (rsp_last)
   );

   // 10-unit clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Gap length: mostly none or short, now and then long; none in burst mode
   function automatic int pick_gap();
      int r;
      if (burst_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Present one pixel request from a falling edge until it is taken
   task automatic send_pixel(input logic [opus_pkg::COL_W-1:0] col,
                             input logic [opus_pkg::ROW_W-1:0] row,
                             input logic on);
      int gap;
      req_valid   <= 1'b1;
      req_column  <= col;
      req_row     <= row;
      req_turn_on <= on;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Receiver back-pressure
   initial begin
      int hold;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         hold = pick_gap();
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   end

   // Handshake monitors and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) bus_sb.note_request(req_column, req_row, req_turn_on);
         if (rsp_valid && rsp_ready) bus_sb.check_result(rsp_is_data, rsp_byte_value, rsp_last);
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_oled_pixel_update_sequencer_top: errors");
         $finish;
      end
   end

   // Stimulus
   initial begin
      logic [opus_pkg::COL_W-1:0] col;
      logic [opus_pkg::ROW_W-1:0] row;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_column  = '0;
      req_row     = '0;
      req_turn_on = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Corners, repeated set and clear leave the byte unchanged
      send_pixel(7'd0, 6'd0, 1'b1);
      send_pixel(7'd127, 6'd63, 1'b1);
      send_pixel(7'd127, 6'd63, 1'b1);
      send_pixel(7'd0, 6'd0, 1'b0);
      send_pixel(7'd0, 6'd0, 1'b0);
      // Fill one whole page byte, then clear single bits: neighbors must survive
      for (int r = 8; r < 16; r++) send_pixel(7'd5, opus_pkg::ROW_W'(r), 1'b1);
      send_pixel(7'd5, 6'd11, 1'b0);
      send_pixel(7'd5, 6'd8, 1'b0);
      // Mid-range addresses and the remaining edges
      send_pixel(7'd64, 6'd31, 1'b1);
      send_pixel(7'd63, 6'd32, 1'b1);
      send_pixel(7'd127, 6'd0, 1'b0);
      send_pixel(7'd0, 6'd63, 1'b1);

      // Random part: mostly a few hot columns so bytes build up and get edited
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % BLOCK_ITEMS == 0) burst_mode = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 99) < 60)
            col = $urandom_range(0, 1) ? opus_pkg::COL_W'($urandom_range(0, 3))
                                       : opus_pkg::COL_W'($urandom_range(124, 127));
         else
            col = opus_pkg::COL_W'($urandom_range(0, opus_pkg::DISPLAY_WIDTH - 1));
         row = opus_pkg::ROW_W'($urandom_range(0, opus_pkg::DISPLAY_HEIGHT - 1));
         send_pixel(col, row, $urandom_range(0, 99) < 60);
      end
      burst_mode = 1'b0;
      req_valid <= 1'b0;

      // Drain, then watch a little longer for stray results
      while (bus_sb.pending() > 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (bus_sb.fault_count == 0)
         $display("tb_oled_pixel_update_sequencer_top: clean");
      else
         $display("tb_oled_pixel_update_sequencer_top: errors");
      $finish;
   end

endmodule
